/* sv/bpa_pkg.sv */
package bpa_pkg;

    localparam int PAGE_COUNT  = 1024;
    localparam int ORDER_COUNT = 11;
    localparam int FRAME_W     = 10;
    localparam int ORDER_W     = 4;
    localparam int ROW_W       = 32;
    localparam int ROW_SH      = 5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_NOT_ALC = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_FREE    = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        K_ALLOC   = 2'd0,
        K_FREE    = 2'd1,
        K_RELEASE = 2'd2,
        K_ERR     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [ORDER_W-1:0]   order;
        logic [FRAME_W-1:0]   frame;
    } cmd_t;

    function automatic int row_base(int k);
        int base;
        base = 0;
        for (int j = 0; j < ORDER_COUNT; j++) begin
            if (j < k) begin
                base += ((PAGE_COUNT >> j) > ROW_W) ? ((PAGE_COUNT >> j) >> ROW_SH) : 1;
            end
        end
        return base;
    endfunction

    localparam int ROW_COUNT = row_base(ORDER_COUNT);
    localparam int ROW_AW    = $clog2(ROW_COUNT);

    function automatic logic [ROW_AW-1:0] row_of(logic [ORDER_W-1:0] k,
                                                 logic [FRAME_W-1:0] b);
        return ROW_AW'(row_base(int'(k)) + int'(b >> ROW_SH));
    endfunction

endpackage

/* sv/buddy_page_allocator_top.sv */
// Buddy page allocator over 1024 frames and orders 0 to 10. After reset a clearing pass
// empties the free bitmaps and allocation records; no word is taken until it ends.
// Each word then runs its steps: allocate scans bitmap rows (up to 68 rows from the
// requested order upward), then splits one level at a time and writes the allocation
// record; free reads and clears the record, then merges order by order; release clears
// the record, then merges order by order; a rejected word goes straight to its result.
// The free bitmap memory holds 32-bit rows. A two-word queue parts intake from execution,
// and a result register lets a finished word wait for m_ready.
module buddy_page_allocator_top import bpa_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [ORDER_W-1:0] s_req_order,
    input  logic [FRAME_W-1:0] s_frame,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [FRAME_W-1:0] m_block_frame,
    output logic [ORDER_W-1:0] m_block_order
);

    cmd_t push_cmd, pop_cmd;
    logic push, pop, q_full, q_empty, init_done;

    bpa_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_req_order (s_req_order),
        .s_frame     (s_frame),
        .q_full      (q_full),
        .init_done   (init_done),
        .push        (push),
        .cmd         (push_cmd)
    );

    bpa_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    bpa_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_cmd         (pop_cmd),
        .pop           (pop),
        .init_done     (init_done),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_block_frame (m_block_frame),
        .m_block_order (m_block_order)
    );

endmodule

/* sv/bpa_front.sv */
module bpa_front import bpa_pkg::*; (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [ORDER_W-1:0] s_req_order,
    input  logic [FRAME_W-1:0] s_frame,
    input  logic               q_full,
    input  logic               init_done,
    output logic               push,
    output cmd_t               cmd
);

    logic [FRAME_W:0] mask;
    logic             order_ok;

    assign order_ok = int'(s_req_order) < ORDER_COUNT;
    assign mask     = (11'(1) << s_req_order) - 11'(1);
    assign s_ready  = !q_full && init_done;
    assign push     = s_valid && s_ready;

    always_comb begin
        cmd.order = s_req_order;
        cmd.frame = s_frame;
        case (s_func)
            FN_ALLOC:   cmd.kind = order_ok ? K_ALLOC : K_ERR;
            FN_FREE:    cmd.kind = K_FREE;
            FN_RELEASE: cmd.kind = (order_ok && ((s_frame & mask[FRAME_W-1:0]) == '0))
                                   ? K_RELEASE : K_ERR;
            default:    cmd.kind = K_ERR;
        endcase
    end

endmodule

/* sv/bpa_fifo.sv */
module bpa_fifo import bpa_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);

    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign pop_cmd = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_cmd;
        end
    end

endmodule

/* sv/bpa_back.sv */
module bpa_back import bpa_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  cmd_t               q_cmd,
    output logic               pop,
    output logic               init_done,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [FRAME_W-1:0] m_block_frame,
    output logic [ORDER_W-1:0] m_block_order
);

    typedef enum logic [11:0] {
        S_CLR  = 12'b000000000001,
        S_IDLE = 12'b000000000010,
        S_ARD  = 12'b000000000100,
        S_ACHK = 12'b000000001000,
        S_SRD  = 12'b000000010000,
        S_SWR  = 12'b000000100000,
        S_AMW  = 12'b000001000000,
        S_FRD  = 12'b000010000000,
        S_FCHK = 12'b000100000000,
        S_MRD  = 12'b001000000000,
        S_MCHK = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } state_t;

    logic [ROW_W-1:0]   fmem [ROW_COUNT];
    logic [ORDER_W:0]   amem [PAGE_COUNT];

    state_t             state_reg, state_next;
    logic [FRAME_W-1:0] clr_reg, clr_next;
    logic [ORDER_W-1:0] k_reg, k_next, ord_reg, ord_next, j_reg, j_next;
    logic [ROW_AW-1:0]  r_reg, r_next, row_reg, row_next;
    logic [FRAME_W-1:0] b_reg, b_next, start_reg, start_next, frame_reg, frame_next;
    logic [ROW_SH-1:0]  bit_reg, bit_next;
    logic               mv_reg, mv_next;
    logic [1:0]         st_reg, st_next, rs_reg, rs_next;
    logic [FRAME_W-1:0] mf_reg, mf_next, rf_reg, rf_next;
    logic [ORDER_W-1:0] mo_reg, mo_next, ro_reg, ro_next;

    logic               f_re, f_we, a_re, a_we;
    logic [ROW_AW-1:0]  f_raddr, f_waddr;
    logic [ROW_W-1:0]   f_wdata, f_rdata_reg;
    logic [FRAME_W-1:0] a_raddr, a_waddr;
    logic [ORDER_W:0]   a_wdata, a_rdata_reg;

    logic [ROW_SH-1:0]  low_pos;
    logic [FRAME_W-1:0] found_b, split_b;
    logic [ORDER_W-1:0] jm1;
    logic [ROW_SH-1:0]  buddy_bit;

    function automatic logic [ROW_SH-1:0] lowest(logic [ROW_W-1:0] v);
        logic [ROW_SH-1:0] p;
        logic              hit;
        p   = '0;
        hit = 1'b0;
        for (int i = 0; i < ROW_W; i++) begin
            if (v[i] && !hit) begin
                p   = ROW_SH'(i);
                hit = 1'b1;
            end
        end
        return p;
    endfunction

    assign init_done     = state_reg != S_CLR;
    assign m_valid       = mv_reg;
    assign m_status      = st_reg;
    assign m_block_frame = mf_reg;
    assign m_block_order = mo_reg;

    assign low_pos   = lowest(f_rdata_reg);
    assign found_b   = FRAME_W'((int'(r_reg) - row_base(int'(k_reg))) << ROW_SH)
                       | FRAME_W'(low_pos);
    assign jm1       = j_reg - ORDER_W'(1);
    assign split_b   = (start_reg >> jm1) + FRAME_W'(1);
    assign buddy_bit = b_reg[ROW_SH-1:0] ^ ROW_SH'(1);

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        k_next     = k_reg;
        ord_next   = ord_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        row_next   = row_reg;
        b_next     = b_reg;
        start_next = start_reg;
        frame_next = frame_reg;
        bit_next   = bit_reg;
        rs_next    = rs_reg;
        rf_next    = rf_reg;
        ro_next    = ro_reg;
        mv_next    = mv_reg && !m_ready;
        st_next    = st_reg;
        mf_next    = mf_reg;
        mo_next    = mo_reg;
        pop        = 1'b0;
        f_re       = 1'b0;
        f_we       = 1'b0;
        a_re       = 1'b0;
        a_we       = 1'b0;
        f_raddr    = r_reg;
        f_waddr    = row_reg;
        f_wdata    = f_rdata_reg;
        a_raddr    = frame_reg;
        a_waddr    = frame_reg;
        a_wdata    = '0;
        case (state_reg)
            S_CLR: begin
                a_we    = 1'b1;
                a_waddr = clr_reg;
                f_we    = int'(clr_reg) < ROW_COUNT;
                f_waddr = clr_reg[ROW_AW-1:0];
                f_wdata = '0;
                clr_next = clr_reg + FRAME_W'(1);
                if (int'(clr_reg) == PAGE_COUNT - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    frame_next = q_cmd.frame;
                    ord_next   = q_cmd.order;
                    k_next     = q_cmd.order;
                    rs_next    = ST_OK;
                    rf_next    = '0;
                    ro_next    = '0;
                    case (q_cmd.kind)
                        K_ALLOC: begin
                            r_next     = ROW_AW'(row_base(int'(q_cmd.order)));
                            state_next = S_ARD;
                        end
                        K_FREE: state_next = S_FRD;
                        K_RELEASE: begin
                            a_we       = 1'b1;
                            a_waddr    = q_cmd.frame;
                            b_next     = q_cmd.frame >> q_cmd.order;
                            state_next = S_MRD;
                        end
                        default: begin
                            rs_next    = ST_BAD;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_ARD: begin
                f_re       = 1'b1;
                state_next = S_ACHK;
            end
            S_ACHK: begin
                if (f_rdata_reg != '0) begin
                    f_we       = 1'b1;
                    f_waddr    = r_reg;
                    f_wdata    = f_rdata_reg & ~(ROW_W'(1) << low_pos);
                    start_next = FRAME_W'(found_b << k_reg);
                    j_next     = k_reg;
                    state_next = (k_reg == ord_reg) ? S_AMW : S_SRD;
                end else if (int'(r_reg) + 1 == row_base(int'(k_reg) + 1)) begin
                    if (int'(k_reg) + 1 == ORDER_COUNT) begin
                        rs_next    = ST_NO_FREE;
                        state_next = S_OUT;
                    end else begin
                        k_next     = k_reg + ORDER_W'(1);
                        r_next     = r_reg + ROW_AW'(1);
                        state_next = S_ARD;
                    end
                end else begin
                    r_next     = r_reg + ROW_AW'(1);
                    state_next = S_ARD;
                end
            end
            S_SRD: begin
                f_re       = 1'b1;
                f_raddr    = row_of(jm1, split_b);
                row_next   = row_of(jm1, split_b);
                bit_next   = split_b[ROW_SH-1:0];
                state_next = S_SWR;
            end
            S_SWR: begin
                f_we       = 1'b1;
                f_wdata    = f_rdata_reg | (ROW_W'(1) << bit_reg);
                j_next     = jm1;
                state_next = (jm1 == ord_reg) ? S_AMW : S_SRD;
            end
            S_AMW: begin
                a_we       = 1'b1;
                a_waddr    = start_reg;
                a_wdata    = {1'b1, ord_reg};
                rf_next    = start_reg;
                ro_next    = ord_reg;
                state_next = S_OUT;
            end
            S_FRD: begin
                a_re       = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK: begin
                if (!a_rdata_reg[ORDER_W]) begin
                    rs_next    = ST_NOT_ALC;
                    state_next = S_OUT;
                end else begin
                    a_we = 1'b1;
                    if (int'(a_rdata_reg[ORDER_W-1:0]) >= ORDER_COUNT) begin
                        rs_next    = ST_BAD;
                        state_next = S_OUT;
                    end else begin
                        k_next     = a_rdata_reg[ORDER_W-1:0];
                        b_next     = frame_reg >> a_rdata_reg[ORDER_W-1:0];
                        state_next = S_MRD;
                    end
                end
            end
            S_MRD: begin
                f_re       = 1'b1;
                f_raddr    = row_of(k_reg, b_reg);
                row_next   = row_of(k_reg, b_reg);
                state_next = S_MCHK;
            end
            S_MCHK: begin
                f_we = 1'b1;
                if ((int'(k_reg) + 1 < ORDER_COUNT) && f_rdata_reg[buddy_bit]) begin
                    f_wdata    = f_rdata_reg & ~(ROW_W'(1) << buddy_bit);
                    b_next     = b_reg >> 1;
                    k_next     = k_reg + ORDER_W'(1);
                    state_next = S_MRD;
                end else begin
                    f_wdata    = f_rdata_reg | (ROW_W'(1) << b_reg[ROW_SH-1:0]);
                    rf_next    = FRAME_W'(b_reg << k_reg);
                    ro_next    = k_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    st_next    = rs_reg;
                    mf_next    = rf_reg;
                    mo_next    = ro_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg     <= k_next;
        ord_reg   <= ord_next;
        j_reg     <= j_next;
        r_reg     <= r_next;
        row_reg   <= row_next;
        b_reg     <= b_next;
        start_reg <= start_next;
        frame_reg <= frame_next;
        bit_reg   <= bit_next;
        rs_reg    <= rs_next;
        rf_reg    <= rf_next;
        ro_reg    <= ro_next;
        st_reg    <= st_next;
        mf_reg    <= mf_next;
        mo_reg    <= mo_next;
    end

    always_ff @(posedge aclk) begin
        if (f_re) begin
            f_rdata_reg <= fmem[f_raddr];
        end
        if (f_we) begin
            fmem[f_waddr] <= f_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_re) begin
            a_rdata_reg <= amem[a_raddr];
        end
        if (a_we) begin
            amem[a_waddr] <= a_wdata;
        end
    end

endmodule
